>>> sv/ifrt_pkg.sv
// ----------------------------------------------------------------------------
// ifrt_pkg: shared types and constants of the fragment reassembly tracker
// Holds the descriptor struct passed from the front to the back, and the result struct.
// ----------------------------------------------------------------------------
package ifrt_pkg;

	localparam int unsigned SLOTS_DEFAULT = 4;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [16:0] MAX_PAYLOAD = 17'd65535;

	localparam logic [1:0] ST_DROP     = 2'd0;
	localparam logic [1:0] ST_PENDING  = 2'd1;
	localparam logic [1:0] ST_COMPLETE = 2'd2;

	// Classified descriptor handed from the front to the back.
	typedef struct packed {
		logic        drop;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [7:0]  protocol;
		logic [15:0] datagram_id;
		logic        more_fragments;
		logic [15:0] byte_offset;
		logic [15:0] payload_length;
		logic [15:0] end_length;
	} desc_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  slot_index;
		logic [15:0] byte_offset;
		logic        evicted;
		logic [15:0] total_length;
	} result_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_UPDATE,
		BK_EMIT
	} back_state_t;

endpackage

>>> sv/ifrt_front.sv
// ----------------------------------------------------------------------------
// ifrt_front: descriptor intake and overflow classification
// Computes the byte offset and end, flags overflow, and queues the item.
// ----------------------------------------------------------------------------
module ifrt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [31:0]         src_addr,
	input  logic [31:0]         dst_addr,
	input  logic [7:0]          protocol,
	input  logic [15:0]         datagram_id,
	input  logic                more_fragments,
	input  logic [12:0]         offset_units,
	input  logic [15:0]         payload_length,
	output logic                q_valid,
	output ifrt_pkg::desc_t     q_desc,
	input  logic                q_take
);

	localparam int unsigned D = ifrt_pkg::QUEUE_DEPTH;

	ifrt_pkg::desc_t mem_q [D];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic [16:0]     end_sum;
	ifrt_pkg::desc_t d;
	logic            wr, rd;

	assign end_sum = {1'b0, offset_units, 3'b000} + {1'b0, payload_length};
	always_comb begin
		d.drop = end_sum > ifrt_pkg::MAX_PAYLOAD;
		d.src_addr = src_addr;
		d.dst_addr = dst_addr;
		d.protocol = protocol;
		d.datagram_id = datagram_id;
		d.more_fragments = more_fragments;
		d.byte_offset = {offset_units, 3'b000};
		d.payload_length = payload_length;
		d.end_length = end_sum[15:0];
	end

	assign full = cnt_q == 2'(D);
	assign q_valid = cnt_q != 2'd0;
	assign wr = push && !full;
	assign rd = q_take && q_valid;
	assign q_desc = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

>>> sv/ifrt_back.sv
// ----------------------------------------------------------------------------
// ifrt_back: slot table and reassembly sequencer
// Scans slots one a cycle for a key match, free slot and oldest slot.
// ----------------------------------------------------------------------------
module ifrt_back #(
	parameter int unsigned SLOTS = ifrt_pkg::SLOTS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  ifrt_pkg::desc_t     q_desc,
	output logic                q_take,
	output logic                empty,
	input  logic                pop,
	output ifrt_pkg::result_t   res
);

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOTS-1:0] act_q, last_q;
	logic [31:0]      src_q [SLOTS];
	logic [31:0]      dst_q [SLOTS];
	logic [7:0]       pro_q [SLOTS];
	logic [15:0]      id_q  [SLOTS];
	logic [15:0]      tot_q [SLOTS];
	logic [15:0]      fil_q [SLOTS];
	logic [31:0]      age_q [SLOTS];
	logic [31:0]      clk_age_q;

	ifrt_pkg::back_state_t st_q, st_d;
	ifrt_pkg::desc_t   cur_q;
	ifrt_pkg::result_t res_q;
	logic [IW:0]       idx_q;
	logic              hit_q, free_q;
	logic [IW-1:0]     hit_i_q, free_i_q, old_i_q;
	logic [31:0]       old_a_q;

	logic [IW-1:0] ci, pick;
	logic          match, alloc;
	logic [16:0]   sum;
	logic [15:0]   fil_n, tot_n;
	logic          last_n;

	assign ci = idx_q[IW-1:0];
	assign match = act_q[ci] && src_q[ci] == cur_q.src_addr && dst_q[ci] == cur_q.dst_addr
		&& pro_q[ci] == cur_q.protocol && id_q[ci] == cur_q.datagram_id;
	assign alloc = !hit_q;
	assign pick = hit_q ? hit_i_q : (free_q ? free_i_q : old_i_q);
	assign sum = (alloc ? 17'd0 : {1'b0, fil_q[pick]}) + {1'b0, cur_q.payload_length};
	assign fil_n = (sum > ifrt_pkg::MAX_PAYLOAD) ? 16'hFFFF : sum[15:0];
	assign tot_n = !cur_q.more_fragments ? cur_q.end_length : (alloc ? 16'd0 : tot_q[pick]);
	assign last_n = !cur_q.more_fragments || (!alloc && last_q[pick]);

	assign empty = st_q != ifrt_pkg::BK_EMIT;
	assign res = res_q;
	assign q_take = st_q == ifrt_pkg::BK_IDLE && q_valid;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ifrt_pkg::BK_IDLE:   if (q_valid) st_d = q_desc.drop ? ifrt_pkg::BK_EMIT
				: ifrt_pkg::BK_SCAN;
			ifrt_pkg::BK_SCAN:   if (idx_q == (IW+1)'(SLOTS - 1)) st_d = ifrt_pkg::BK_UPDATE;
			ifrt_pkg::BK_UPDATE: st_d = ifrt_pkg::BK_EMIT;
			ifrt_pkg::BK_EMIT:   if (pop) st_d = ifrt_pkg::BK_IDLE;
			default:             st_d = ifrt_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			cur_q <= q_desc;
			res_q <= '{status: ifrt_pkg::ST_DROP, slot_index: 2'd0, byte_offset: 16'd0,
				evicted: 1'b0, total_length: 16'd0};
		end
		if (st_q == ifrt_pkg::BK_SCAN) begin
			if (match && !hit_q) hit_i_q <= ci;
			if (!act_q[ci] && !free_q) free_i_q <= ci;
			if (idx_q == '0 || age_q[ci] < old_a_q) begin
				old_i_q <= ci;
				old_a_q <= age_q[ci];
			end
		end
		if (st_q == ifrt_pkg::BK_UPDATE) begin
			res_q.slot_index <= 2'(pick);
			res_q.byte_offset <= cur_q.byte_offset;
			res_q.evicted <= alloc && !free_q;
			if (last_n && fil_n >= tot_n) begin
				res_q.status <= ifrt_pkg::ST_COMPLETE;
				res_q.total_length <= tot_n;
			end else begin
				res_q.status <= ifrt_pkg::ST_PENDING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ifrt_pkg::BK_IDLE;
			act_q <= '0;
			last_q <= '0;
			clk_age_q <= '0;
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				src_q[i] <= '0; dst_q[i] <= '0; pro_q[i] <= '0; id_q[i] <= '0;
				tot_q[i] <= '0; fil_q[i] <= '0; age_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (q_take) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
			end
			if (st_q == ifrt_pkg::BK_SCAN) begin
				idx_q <= idx_q + 1'b1;
				if (match) hit_q <= 1'b1;
				if (!act_q[ci]) free_q <= 1'b1;
			end
			if (st_q == ifrt_pkg::BK_UPDATE) begin
				if (alloc) begin
					src_q[pick] <= cur_q.src_addr;
					dst_q[pick] <= cur_q.dst_addr;
					pro_q[pick] <= cur_q.protocol;
					id_q[pick]  <= cur_q.datagram_id;
				end
				fil_q[pick] <= fil_n;
				tot_q[pick] <= tot_n;
				age_q[pick] <= alloc ? clk_age_q + 32'd1 : clk_age_q;
				last_q[pick] <= last_n;
				act_q[pick] <= !(last_n && fil_n >= tot_n);
				clk_age_q <= clk_age_q + (alloc ? 32'd2 : 32'd1);
			end
		end
	end

endmodule

>>> sv/ipv4_fragment_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// ipv4_fragment_reassembly_tracker: IPv4 fragment bookkeeping
// Matches fragment descriptors to reassembly slots and reports completion.
// ----------------------------------------------------------------------------
// Each pushed item is one fragment descriptor and yields exactly one result
// item, in order. The front checks offset*8+length against 65535 and places
// the item in a two-entry queue. The back walks the slot table one slot per
// cycle, so a kept fragment passes the scan and the update state before
// reaching the result port, and a dropped one skips both. The result waits in
// a register until popped, while the front keeps taking up to two new items.
module ipv4_fragment_reassembly_tracker #(
	parameter int unsigned SLOTS = ifrt_pkg::SLOTS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [7:0]  protocol,
	input  logic [15:0] datagram_id,
	input  logic        more_fragments,
	input  logic [12:0] offset_units,
	input  logic [15:0] payload_length,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [1:0]  slot_index,
	output logic [15:0] byte_offset,
	output logic        evicted,
	output logic [15:0] total_length
);

	logic              q_valid, q_take;
	ifrt_pkg::desc_t   q_desc;
	ifrt_pkg::result_t res;

	// Front: classification and the item queue.
	ifrt_front u_front (
		.clk, .arst_n, .push, .full, .src_addr, .dst_addr, .protocol, .datagram_id,
		.more_fragments, .offset_units, .payload_length, .q_valid, .q_desc, .q_take
	);

	// Back: slot search, update and the result register.
	ifrt_back #(.SLOTS(SLOTS)) u_back (
		.clk, .arst_n, .q_valid, .q_desc, .q_take, .empty, .pop, .res
	);

	assign status = res.status;
	assign slot_index = res.slot_index;
	assign byte_offset = res.byte_offset;
	assign evicted = res.evicted;
	assign total_length = res.total_length;

	// A dropped item reports nothing but its status.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ifrt_pkg::ST_DROP) |-> (slot_index == 2'd0 && evicted == 1'b0
		&& total_length == 16'd0 && byte_offset == 16'd0))
		else $error("dropped item carries nonzero fields");

	// Only a completed datagram reports a total length.
	a_total_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ifrt_pkg::ST_COMPLETE) |-> total_length == 16'd0)
		else $error("total length on incomplete item");

	// A waiting result holds until popped.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(slot_index)))
		else $error("result changed while waiting");

endmodule
